[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`endif

[hw/rtl/mrs_pkg.sv]
// Types and constants of the Modbus RTU register slave.
package mrs_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    localparam logic [7:0] EXC_FLAG  = 8'h80;
    localparam logic [7:0] FN_READ   = 8'd3;
    localparam logic [7:0] FN_WRITE1 = 8'd6;
    localparam logic [7:0] FN_WRITEN = 8'd16;
    localparam logic [7:0] EXC_FUNC  = 8'd1;
    localparam logic [7:0] EXC_ADDR  = 8'd2;
    localparam logic [7:0] EXC_VALUE = 8'd3;

    localparam logic [1:0] CFG_SLAVE_ID = 2'd0;
    localparam logic [1:0] CFG_BASE     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    localparam logic [16:0] IDLE_MAX  = 17'h1FFFF;
    localparam int          MIN_FRAME = 8;
    localparam int          BC_OFFSET = 9;
    localparam int          HDR_BYTES = 7;
    localparam int          ECHO_BYTES = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_FEED,
        ST_CHK_WAIT,
        ST_DECIDE,
        ST_WR_RDH,
        ST_WR_RDL,
        ST_WR_ST,
        ST_TX_INIT,
        ST_TX_BYTE,
        ST_TX_WAIT,
        ST_TX_CRCL,
        ST_TX_CRCH
    } t_state;

    typedef enum logic [1:0] {
        RESP_EXC,
        RESP_READ,
        RESP_ECHO
    } t_resp;

    typedef enum logic [2:0] {
        V_DROP,
        V_EXC,
        V_READ,
        V_WRITE1,
        V_WRITEN
    } t_verdict;

    typedef struct packed {
        logic       init;
        logic       feed;
        logic [7:0] data;
    } t_crc_ctl;

endpackage

[hw/rtl/mrs_crc.sv]
// Bit-serial CRC-16 unit: one polynomial step per cycle.
`include "assert_macros.svh"

module mrs_crc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrs_pkg::t_crc_ctl i_ctl,
    output logic [15:0]       o_crc,
    output logic              o_busy
);

    logic [15:0] r_crc;
    logic [3:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.init) begin
            r_cnt <= '0;
        end else if (i_ctl.feed) begin
            r_cnt <= mrs_pkg::BITS_PER_BYTE;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_crc <= mrs_pkg::CRC_INIT;
        end else if (i_ctl.feed) begin
            r_crc <= r_crc ^ {8'h00, i_ctl.data};
        end else if (r_cnt != '0) begin
            // shift one bit, fold in the reflected polynomial
            r_crc <= r_crc[0] ? ((r_crc >> 1) ^ mrs_pkg::CRC_POLY) : (r_crc >> 1);
        end
    end

    assign o_crc  = r_crc;
    assign o_busy = (r_cnt != '0);

    `ASSERT_NEVER(a_no_feed_busy, i_clk, i_rst_n, i_ctl.feed && o_busy, "byte fed mid shift")
    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_cnt <= mrs_pkg::BITS_PER_BYTE, "bit count out of range")

endmodule

[hw/rtl/modbus_rtu_register_slave.sv]
// Top level of the Modbus RTU holding register slave.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------
//  item      | in        | start && !busy          | i_func, i_rx_byte, i_frame_end
//  result    | out       | o_strobe, one cycle     | o_kind, o_tx_byte, o_last_byte, o_alarm
//  config    | in        | i_cfg_valid && o_cfg_ready | i_cfg_index, i_cfg_data
//
// A tick or a byte inside a frame is taken without leaving idle. A frame end walks
// the frame through the bit-serial CRC unit, decides, stores each register on a
// write multiple, restarts the CRC, then sends the answer body bytes and the two
// CRC bytes, since each outgoing byte goes through the same CRC unit. A dropped
// frame gets no answer.
// Reset is synchronous and active low; the register file clears at once.
// Results cannot be stalled: each beat is on the ports for exactly one cycle.
// Config is always ready and takes effect on the next cycle.
`include "assert_macros.svh"

module modbus_rtu_register_slave #(
    parameter int FRAME_BYTES = 64,
    parameter int REG_COUNT   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_strobe,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    output logic        o_alarm,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int NW = $clog2(FRAME_BYTES + 1);
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int KW = $clog2(2 * REG_COUNT + 4);
    localparam int QW = $clog2(REG_COUNT + 1);

    mrs_pkg::t_state r_state, n_state;

    // configuration
    logic [7:0]  r_slave_id;
    logic [15:0] r_base;
    logic [15:0] r_timeout;

    // frame collection
    logic [7:0]    r_frame [FRAME_BYTES];
    logic [7:0]    r_rd_data;
    logic [NW-1:0] r_byte_count;
    logic          r_ovf;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_idx;
    logic [7:0]    r_hdr [mrs_pkg::HDR_BYTES];

    // register file and timeout
    logic [15:0] r_hold [REG_COUNT];
    logic [16:0] r_idle;
    logic        r_alarm;

    // answer sequencing
    mrs_pkg::t_resp r_resp;
    logic [7:0]     r_code;
    logic [KW-1:0]  r_body_len;
    logic [KW-1:0]  r_k;
    logic [RW-1:0]  r_ptr;
    logic           r_hi;
    logic [7:0]     r_wr_hi;
    logic [QW-1:0]  r_cnt;

    // result beat
    logic       r_strobe;
    logic       r_kind;
    logic [7:0] r_tx;
    logic       r_last;
    logic       r_out_alarm;

    mrs_pkg::t_crc_ctl crc_ctl;
    logic [15:0]       crc;
    logic              crc_busy;

    logic          accept;
    logic          byte_fits;
    logic [NW-1:0] n_count;
    logic          n_ovf;
    logic [16:0]   n_idle;

    logic [7:0]  fn;
    logic [15:0] start_addr;
    logic [15:0] qty;
    logic        below;
    logic [15:0] off;
    logic [16:0] span;
    logic        too_many;
    logic        off_out;
    logic [NW:0] n_minus;
    logic        bc_ok;
    logic        bc_pair;
    mrs_pkg::t_verdict verdict;
    logic [7:0]  verdict_code;
    logic [7:0]  body_byte;

    assign accept      = start && !busy;
    assign busy        = (r_state != mrs_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign byte_fits = (r_byte_count < NW'(FRAME_BYTES));
    assign n_count   = byte_fits ? (r_byte_count + NW'(1)) : r_byte_count;
    assign n_ovf     = r_ovf || !byte_fits;
    assign n_idle    = (r_idle == mrs_pkg::IDLE_MAX) ? r_idle : (r_idle + 17'd1);

    // request decode from the captured header
    assign fn         = r_hdr[1];
    assign start_addr = {r_hdr[2], r_hdr[3]};
    assign qty        = {r_hdr[4], r_hdr[5]};
    assign below      = (start_addr < r_base);
    assign off        = start_addr - r_base;
    assign span       = {1'b0, off} + {1'b0, qty};
    assign too_many   = (qty == 16'd0) || (span > 17'(REG_COUNT));
    assign off_out    = (off >= 16'(REG_COUNT));
    assign n_minus    = {1'b0, r_n} - (NW+1)'(mrs_pkg::BC_OFFSET);
    assign bc_ok      = (r_n != NW'(mrs_pkg::MIN_FRAME)) && (16'(n_minus) == {8'h00, r_hdr[6]});
    assign bc_pair    = ({9'h000, r_hdr[6]} == {qty, 1'b0});

    always_comb begin
        verdict      = mrs_pkg::V_DROP;
        verdict_code = mrs_pkg::EXC_FUNC;
        if (crc == 16'h0000 && r_hdr[0] == r_slave_id) begin
            case (fn)
                mrs_pkg::FN_READ: begin
                    if (below) begin
                        verdict = mrs_pkg::V_EXC;  verdict_code = mrs_pkg::EXC_ADDR;
                    end else if (too_many) begin
                        verdict = mrs_pkg::V_EXC;  verdict_code = mrs_pkg::EXC_VALUE;
                    end else begin
                        verdict = mrs_pkg::V_READ;
                    end
                end
                mrs_pkg::FN_WRITE1: begin
                    if (below || off_out) begin
                        verdict = mrs_pkg::V_EXC;  verdict_code = mrs_pkg::EXC_ADDR;
                    end else begin
                        verdict = mrs_pkg::V_WRITE1;
                    end
                end
                mrs_pkg::FN_WRITEN: begin
                    if (!bc_ok) begin
                        verdict = mrs_pkg::V_DROP;
                    end else if (below) begin
                        verdict = mrs_pkg::V_EXC;  verdict_code = mrs_pkg::EXC_ADDR;
                    end else if (too_many || !bc_pair) begin
                        verdict = mrs_pkg::V_EXC;  verdict_code = mrs_pkg::EXC_VALUE;
                    end else begin
                        verdict = mrs_pkg::V_WRITEN;
                    end
                end
                default: begin
                    verdict = mrs_pkg::V_EXC;  verdict_code = mrs_pkg::EXC_FUNC;
                end
            endcase
        end
    end

    // answer body byte at position r_k
    always_comb begin
        body_byte = 8'h00;
        case (r_resp)
            mrs_pkg::RESP_EXC: begin
                if (r_k == KW'(0))      body_byte = r_slave_id;
                else if (r_k == KW'(1)) body_byte = mrs_pkg::EXC_FLAG | fn;
                else                    body_byte = r_code;
            end
            mrs_pkg::RESP_READ: begin
                if (r_k == KW'(0))      body_byte = r_hdr[0];
                else if (r_k == KW'(1)) body_byte = r_hdr[1];
                else if (r_k == KW'(2)) body_byte = {r_hdr[5][6:0], 1'b0};
                else                    body_byte = r_hi ? r_hold[r_ptr][15:8] : r_hold[r_ptr][7:0];
            end
            mrs_pkg::RESP_ECHO: begin
                body_byte = r_hdr[r_k[2:0]];
            end
            default: body_byte = 8'h00;
        endcase
    end

    // sequencer: next state and CRC unit control
    always_comb begin
        n_state      = r_state;
        crc_ctl.init = 1'b0;
        crc_ctl.feed = 1'b0;
        crc_ctl.data = r_rd_data;
        case (r_state)
            mrs_pkg::ST_IDLE: begin
                if (accept && !i_func && i_frame_end) begin
                    crc_ctl.init = 1'b1;
                    // drop short or overflowing frames right away
                    if (!n_ovf && n_count >= NW'(mrs_pkg::MIN_FRAME)) begin
                        n_state = mrs_pkg::ST_CHK_RD;
                    end
                end
            end
            mrs_pkg::ST_CHK_RD:   n_state = mrs_pkg::ST_CHK_FEED;
            mrs_pkg::ST_CHK_FEED: begin
                crc_ctl.feed = 1'b1;
                n_state      = mrs_pkg::ST_CHK_WAIT;
            end
            mrs_pkg::ST_CHK_WAIT: begin
                if (!crc_busy) begin
                    n_state = (r_idx + NW'(1) == r_n) ? mrs_pkg::ST_DECIDE : mrs_pkg::ST_CHK_RD;
                end
            end
            mrs_pkg::ST_DECIDE: begin
                case (verdict)
                    mrs_pkg::V_DROP:   n_state = mrs_pkg::ST_IDLE;
                    mrs_pkg::V_WRITEN: n_state = mrs_pkg::ST_WR_RDH;
                    default:           n_state = mrs_pkg::ST_TX_INIT;
                endcase
            end
            mrs_pkg::ST_WR_RDH: n_state = mrs_pkg::ST_WR_RDL;
            mrs_pkg::ST_WR_RDL: n_state = mrs_pkg::ST_WR_ST;
            mrs_pkg::ST_WR_ST: begin
                n_state = (r_cnt == QW'(1)) ? mrs_pkg::ST_TX_INIT : mrs_pkg::ST_WR_RDH;
            end
            mrs_pkg::ST_TX_INIT: begin
                crc_ctl.init = 1'b1;
                n_state      = mrs_pkg::ST_TX_BYTE;
            end
            mrs_pkg::ST_TX_BYTE: begin
                crc_ctl.feed = 1'b1;
                crc_ctl.data = body_byte;
                n_state      = mrs_pkg::ST_TX_WAIT;
            end
            mrs_pkg::ST_TX_WAIT: begin
                if (!crc_busy) begin
                    n_state = (r_k == r_body_len) ? mrs_pkg::ST_TX_CRCL : mrs_pkg::ST_TX_BYTE;
                end
            end
            mrs_pkg::ST_TX_CRCL: n_state = mrs_pkg::ST_TX_CRCH;
            mrs_pkg::ST_TX_CRCH: n_state = mrs_pkg::ST_IDLE;
            default:             n_state = mrs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    mrs_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc),
        .o_busy  (crc_busy)
    );

    // frame memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == mrs_pkg::ST_IDLE && accept && !i_func && byte_fits) begin
            r_frame[r_byte_count[AW-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_frame[r_idx[AW-1:0]];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id <= 8'd1;
            r_base     <= 16'd0;
            r_timeout  <= 16'd1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mrs_pkg::CFG_SLAVE_ID: r_slave_id <= i_cfg_data[7:0];
                mrs_pkg::CFG_BASE:     r_base     <= i_cfg_data;
                mrs_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                default:               ;
            endcase
        end
    end

    // control state: counts, flags, register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_ovf        <= 1'b0;
            r_idle       <= '0;
            r_alarm      <= 1'b0;
            r_strobe     <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_hold[i] <= 16'h0000;
            end
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                mrs_pkg::ST_IDLE: begin
                    if (accept && i_func) begin
                        // tick: count idle time, raise alarm, report status
                        r_idle <= n_idle;
                        if (n_idle > {1'b0, r_timeout}) begin
                            r_alarm <= 1'b1;
                        end
                        r_strobe    <= 1'b1;
                        r_kind      <= 1'b1;
                        r_tx        <= 8'h00;
                        r_last      <= 1'b1;
                        r_out_alarm <= r_alarm || (n_idle > {1'b0, r_timeout});
                    end else if (accept) begin
                        r_idle <= '0;
                        if (i_frame_end) begin
                            r_n          <= n_count;
                            r_byte_count <= '0;
                            r_ovf        <= 1'b0;
                        end else begin
                            r_byte_count <= n_count;
                            r_ovf        <= n_ovf;
                        end
                    end
                    r_idx <= '0;
                end
                mrs_pkg::ST_CHK_FEED: begin
                    if (r_idx < NW'(mrs_pkg::HDR_BYTES)) begin
                        r_hdr[r_idx[2:0]] <= r_rd_data;
                    end
                end
                mrs_pkg::ST_CHK_WAIT: begin
                    if (!crc_busy) begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
                mrs_pkg::ST_DECIDE: begin
                    r_code     <= verdict_code;
                    r_ptr      <= off[RW-1:0];
                    r_hi       <= 1'b1;
                    r_cnt      <= qty[QW-1:0];
                    r_idx      <= NW'(mrs_pkg::HDR_BYTES);
                    r_resp     <= mrs_pkg::RESP_ECHO;
                    r_body_len <= KW'(mrs_pkg::ECHO_BYTES);
                    case (verdict)
                        mrs_pkg::V_EXC: begin
                            r_resp     <= mrs_pkg::RESP_EXC;
                            r_body_len <= KW'(3);
                        end
                        mrs_pkg::V_READ: begin
                            r_resp     <= mrs_pkg::RESP_READ;
                            r_body_len <= KW'({qty, 1'b0}) + KW'(3);
                            r_alarm    <= 1'b0;
                        end
                        mrs_pkg::V_WRITE1: begin
                            r_hold[off[RW-1:0]] <= qty;
                            r_alarm             <= 1'b0;
                        end
                        mrs_pkg::V_WRITEN: begin
                            r_alarm <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                mrs_pkg::ST_WR_RDH: begin
                    r_idx <= r_idx + NW'(1);
                end
                mrs_pkg::ST_WR_RDL: begin
                    r_wr_hi <= r_rd_data;
                    r_idx   <= r_idx + NW'(1);
                end
                mrs_pkg::ST_WR_ST: begin
                    r_hold[r_ptr] <= {r_wr_hi, r_rd_data};
                    r_ptr         <= r_ptr + RW'(1);
                    r_cnt         <= r_cnt - QW'(1);
                end
                mrs_pkg::ST_TX_INIT: begin
                    r_k <= '0;
                end
                mrs_pkg::ST_TX_BYTE: begin
                    r_strobe    <= 1'b1;
                    r_kind      <= 1'b0;
                    r_tx        <= body_byte;
                    r_last      <= 1'b0;
                    r_out_alarm <= r_alarm;
                    r_k         <= r_k + KW'(1);
                    // advance through the read registers, high byte first
                    if (r_resp == mrs_pkg::RESP_READ && r_k >= KW'(3)) begin
                        r_hi <= !r_hi;
                        if (!r_hi) begin
                            r_ptr <= r_ptr + RW'(1);
                        end
                    end
                end
                mrs_pkg::ST_TX_CRCL: begin
                    r_strobe    <= 1'b1;
                    r_kind      <= 1'b0;
                    r_tx        <= crc[7:0];
                    r_last      <= 1'b0;
                    r_out_alarm <= r_alarm;
                end
                mrs_pkg::ST_TX_CRCH: begin
                    r_strobe    <= 1'b1;
                    r_kind      <= 1'b0;
                    r_tx        <= crc[15:8];
                    r_last      <= 1'b1;
                    r_out_alarm <= r_alarm;
                end
                default: ;
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_kind      = r_kind;
    assign o_tx_byte   = r_tx;
    assign o_last_byte = r_last;
    assign o_alarm     = r_out_alarm;

    `ASSERT_CLK(a_resp_from_busy, i_clk, i_rst_n, o_strobe && !o_kind |-> $past(busy), "answer beat while idle")
    `ASSERT_CLK(a_status_shape, i_clk, i_rst_n, o_strobe && o_kind |-> o_last_byte && o_tx_byte == 8'h00, "bad status beat")
    `ASSERT_CLK(a_tick_status, i_clk, i_rst_n, start && !busy && i_func |=> o_strobe && o_kind, "tick without status")

endmodule

[tb/sv/tb_modbus_rtu_register_slave.sv]
// Self-checking testbench for the Modbus RTU holding register slave.
`timescale 1ns / 1ps

module tb_modbus_rtu_register_slave;

    localparam int FRAME_MAX  = 64;
    localparam int REGS       = 16;
    localparam int SETTLE     = 60;
    localparam int ITEM_GOAL  = 130;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_SETTLE
    } t_op_kind;

    typedef struct {
        t_op_kind    kind;
        logic        func;
        logic [7:0]  rx;
        logic        fend;
        logic [1:0]  idx;
        logic [15:0] data;
        int          gap;
    } t_pend_op;

    typedef struct {
        logic       kind;
        logic [7:0] tx;
        logic       last;
        logic       alarm;
    } t_tx_beat;

    typedef logic [7:0] t_byte_q[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        item_start = 1'b0;
    logic        busy;
    logic        i_func = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_frame_end = 1'b0;
    logic        o_strobe;
    logic        o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last_byte;
    logic        o_alarm;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    modbus_rtu_register_slave dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (item_start),
        .busy        (busy),
        .i_func      (i_func),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .o_strobe    (o_strobe),
        .o_kind      (o_kind),
        .o_tx_byte   (o_tx_byte),
        .o_last_byte (o_last_byte),
        .o_alarm     (o_alarm),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predicted slave state: its own copy of config, frame and registers
    // ---------------------------------------------------------------
    logic [7:0]  my_id = 8'd1;
    logic [15:0] my_base = 16'd0;
    logic [15:0] my_timeout = 16'd1000;
    logic [7:0]  rx_frame[FRAME_MAX];
    int          rx_count = 0;
    logic        rx_over = 1'b0;
    logic [15:0] hold_regs[REGS];
    logic [16:0] quiet_ms = '0;
    logic        comm_alarm = 1'b0;
    logic [7:0]  answer[64];

    t_tx_beat    awaited_beats[$];
    t_pend_op    pending_ops[$];
    int          fails = 0;

    initial for (int i = 0; i < REGS; i++) hold_regs[i] = '0;

    // One byte of the reflected CRC-16 (poly 0xA001)
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ mrs_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // Append CRC low byte first to the answer buffer
    function automatic int seal_answer(input int len);
        logic [15:0] c;
        c = mrs_pkg::CRC_INIT;
        for (int k = 0; k < len; k++) c = crc_byte(c, answer[k]);
        answer[len]     = c[7:0];
        answer[len + 1] = c[15:8];
        return len + 2;
    endfunction

    function automatic int exception_answer(input logic [7:0] fn, input logic [7:0] code);
        answer[0] = my_id;
        answer[1] = mrs_pkg::EXC_FLAG | fn;
        answer[2] = code;
        return seal_answer(3);
    endfunction

    // Serve a closed frame; return the answer length, zero when dropped
    function automatic int serve_frame();
        logic [15:0] c;
        logic [7:0]  fn;
        int          n, st, qty, off;
        n = rx_count;
        if (rx_over || n < mrs_pkg::MIN_FRAME) return 0;
        if (rx_frame[0] != my_id) return 0;
        c = mrs_pkg::CRC_INIT;
        for (int k = 0; k < n - 2; k++) c = crc_byte(c, rx_frame[k]);
        if (c != {rx_frame[n - 1], rx_frame[n - 2]}) return 0;
        fn  = rx_frame[1];
        st  = {rx_frame[2], rx_frame[3]};
        qty = {rx_frame[4], rx_frame[5]};
        off = (st >= my_base) ? st - my_base : 0;
        if (fn == mrs_pkg::FN_READ) begin
            if (st < my_base) return exception_answer(fn, mrs_pkg::EXC_ADDR);
            if (qty == 0 || off + qty > REGS) return exception_answer(fn, mrs_pkg::EXC_VALUE);
            answer[0] = rx_frame[0];
            answer[1] = fn;
            answer[2] = 8'(2 * qty);
            for (int k = 0; k < qty; k++) begin
                answer[3 + 2 * k] = hold_regs[off + k][15:8];
                answer[4 + 2 * k] = hold_regs[off + k][7:0];
            end
            comm_alarm = 1'b0;
            return seal_answer(3 + 2 * qty);
        end
        if (fn == mrs_pkg::FN_WRITE1) begin
            if (st < my_base || off >= REGS) return exception_answer(fn, mrs_pkg::EXC_ADDR);
            hold_regs[off] = 16'(qty);
            for (int k = 0; k < mrs_pkg::ECHO_BYTES; k++) answer[k] = rx_frame[k];
            comm_alarm = 1'b0;
            return seal_answer(mrs_pkg::ECHO_BYTES);
        end
        if (fn == mrs_pkg::FN_WRITEN) begin
            // wrong byte count is dropped without an answer
            if (n < mrs_pkg::BC_OFFSET || int'(rx_frame[6]) != n - mrs_pkg::BC_OFFSET) return 0;
            if (st < my_base) return exception_answer(fn, mrs_pkg::EXC_ADDR);
            if (qty == 0 || off + qty > REGS || int'(rx_frame[6]) != 2 * qty)
                return exception_answer(fn, mrs_pkg::EXC_VALUE);
            for (int k = 0; k < qty; k++)
                hold_regs[off + k] = {rx_frame[mrs_pkg::HDR_BYTES + 2 * k],
                                      rx_frame[mrs_pkg::HDR_BYTES + 1 + 2 * k]};
            for (int k = 0; k < mrs_pkg::ECHO_BYTES; k++) answer[k] = rx_frame[k];
            comm_alarm = 1'b0;
            return seal_answer(mrs_pkg::ECHO_BYTES);
        end
        return exception_answer(fn, mrs_pkg::EXC_FUNC);
    endfunction

    // Advance the predicted state by one accepted beat and queue its answers
    task automatic predict_beat(input logic fn_tick, input logic [7:0] b, input logic fend);
        t_tx_beat t;
        int       len;
        if (fn_tick) begin
            if (quiet_ms < mrs_pkg::IDLE_MAX) quiet_ms++;
            if (quiet_ms > {1'b0, my_timeout}) comm_alarm = 1'b1;
            t = '{1'b1, 8'h00, 1'b1, comm_alarm};
            awaited_beats.push_back(t);
        end else begin
            quiet_ms = '0;
            if (rx_count < FRAME_MAX) begin
                rx_frame[rx_count] = b;
                rx_count++;
            end else begin
                rx_over = 1'b1;
            end
            if (fend) begin
                len = serve_frame();
                rx_count = 0;
                rx_over  = 1'b0;
                for (int k = 0; k < len; k++) begin
                    t = '{1'b0, answer[k], k == len - 1, comm_alarm};
                    awaited_beats.push_back(t);
                end
            end
        end
    endtask

    task automatic apply_cfg(input logic [1:0] idx, input logic [15:0] d);
        case (idx)
            mrs_pkg::CFG_SLAVE_ID: my_id = d[7:0];
            mrs_pkg::CFG_BASE:     my_base = d;
            mrs_pkg::CFG_TIMEOUT:  my_timeout = d;
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Driver: launch pending beats, hold while busy, settle before config
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin : drive
        logic nx_start, nx_cfg;
        if (!i_rst_n) begin
            item_start <= 1'b0;
            cfg_valid  <= 1'b0;
        end else begin
            nx_start = item_start;
            nx_cfg   = cfg_valid;
            if (item_start && !busy) begin
                predict_beat(i_func, i_rx_byte, i_frame_end);
                nx_start = 1'b0;
            end
            if (cfg_valid && o_cfg_ready) begin
                apply_cfg(i_cfg_index, i_cfg_data);
                nx_cfg = 1'b0;
            end
            if (awaited_beats.size() == 0 && !busy) quiet_cycles++;
            else quiet_cycles = 0;
            if (!nx_start && !nx_cfg && pending_ops.size() > 0) begin
                if (pending_ops[0].gap > 0) begin
                    pending_ops[0].gap--;
                end else begin
                    case (pending_ops[0].kind)
                        OP_ITEM: begin
                            nx_start = 1'b1;
                            i_func      <= pending_ops[0].func;
                            i_rx_byte   <= pending_ops[0].rx;
                            i_frame_end <= pending_ops[0].fend;
                            void'(pending_ops.pop_front());
                        end
                        OP_CFG: if (quiet_cycles >= SETTLE) begin
                            nx_cfg = 1'b1;
                            i_cfg_index <= pending_ops[0].idx;
                            i_cfg_data  <= pending_ops[0].data;
                            void'(pending_ops.pop_front());
                        end
                        default: if (quiet_cycles >= SETTLE) void'(pending_ops.pop_front());
                    endcase
                end
            end
            item_start <= nx_start;
            cfg_valid  <= nx_cfg;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every strobed beat against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_tx_beat e;
        if (i_rst_n && o_strobe) begin
            if (awaited_beats.size() == 0) begin
                $error("unexpected result beat: kind %0d tx_byte %02h", o_kind, o_tx_byte);
                fails++;
            end else begin
                e = awaited_beats.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind: expected %0d, actual %0d", e.kind, o_kind);
                    fails++;
                end
                if (o_tx_byte !== e.tx) begin
                    $error("tx_byte: expected %02h, actual %02h", e.tx, o_tx_byte);
                    fails++;
                end
                if (o_last_byte !== e.last) begin
                    $error("last_byte: expected %0d, actual %0d", e.last, o_last_byte);
                    fails++;
                end
                if (o_alarm !== e.alarm) begin
                    $error("alarm: expected %0d, actual %0d", e.alarm, o_alarm);
                    fails++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    int          item_total = 0;
    int          burst_left = 0;
    logic [7:0]  cur_id = 8'd1;
    logic [15:0] cur_base = 16'd0;

    // Gaps come in stretches: some back to back, some with random idles
    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(5, 20);
        return $urandom_range(0, 8);
    endfunction

    task automatic push_beat(input logic f, input logic [7:0] b, input logic fe);
        pending_ops.push_back('{OP_ITEM, f, b, fe, 2'd0, 16'd0, draw_gap()});
        item_total++;
    endtask

    task automatic push_tick();
        push_beat(1'b1, 8'($urandom), 1'($urandom));
    endtask

    task automatic push_cfg(input logic [1:0] idx, input logic [15:0] d);
        pending_ops.push_back('{OP_CFG, 1'b0, 8'd0, 1'b0, idx, d, 0});
        if (idx == mrs_pkg::CFG_SLAVE_ID) cur_id = d[7:0];
        if (idx == mrs_pkg::CFG_BASE) cur_base = d;
    endtask

    task automatic push_settle();
        pending_ops.push_back('{OP_SETTLE, 1'b0, 8'd0, 1'b0, 2'd0, 16'd0, 0});
    endtask

    // Send a frame, sealed with a good or a broken CRC
    task automatic push_frame(input t_byte_q body, input bit crc_ok);
        logic [15:0] c;
        c = mrs_pkg::CRC_INIT;
        foreach (body[k]) c = crc_byte(c, body[k]);
        if (!crc_ok) c ^= 16'(1 << $urandom_range(0, 15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[k]) push_beat(1'b0, body[k], k == body.size() - 1);
    endtask

    // Random frame: mostly well formed requests with random content
    task automatic push_random_frame();
        t_byte_q     f;
        logic [7:0]  id;
        logic [15:0] st, qty;
        int          pick, n, bc;
        id   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_id;
        st   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : cur_base + 16'($urandom_range(0, 18));
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            qty = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            f = '{id, mrs_pkg::FN_READ, st[15:8], st[7:0], qty[15:8], qty[7:0]};
        end else if (pick < 6) begin
            qty = 16'($urandom);
            f = '{id, mrs_pkg::FN_WRITE1, st[15:8], st[7:0], qty[15:8], qty[7:0]};
        end else if (pick < 9) begin
            n   = $urandom_range(0, 5);
            qty = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(n);
            bc  = ($urandom_range(0, 7) == 0) ? 2 * n + 1 : 2 * n;
            f = '{id, mrs_pkg::FN_WRITEN, st[15:8], st[7:0], qty[15:8], qty[7:0], 8'(bc)};
            // occasionally a byte count that disagrees with the length
            if ($urandom_range(0, 9) == 0) bc = bc + 1;
            for (int k = 0; k < bc; k++) f.push_back(8'($urandom));
        end else begin
            f = '{id, 8'($urandom), st[15:8], st[7:0], 8'($urandom), 8'($urandom)};
        end
        if ($urandom_range(0, 11) == 0) begin
            // truncate to a short frame now and then
            while (f.size() > 4) void'(f.pop_back());
        end
        push_frame(f, $urandom_range(0, 9) != 0);
    endtask

    initial begin : stimulus
        t_byte_q f;

        // --- directed: default config ---
        push_frame('{8'd1, mrs_pkg::FN_WRITE1, 8'h00, 8'h00, 8'hFF, 8'hFF}, 1);  // reg 0 all ones
        push_frame('{8'd1, mrs_pkg::FN_WRITE1, 8'h00, 8'h0F, 8'h00, 8'h00}, 1);  // top reg zero
        push_frame('{8'd1, mrs_pkg::FN_WRITEN, 8'h00, 8'h02, 8'h00, 8'h02, 8'h04,
                     8'h80, 8'h01, 8'h7F, 8'hFE}, 1);
        push_frame('{8'd1, mrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h10}, 1);    // all 16 regs
        push_frame('{8'd1, mrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h00}, 1);    // zero quantity
        push_frame('{8'd1, mrs_pkg::FN_READ, 8'h00, 8'h0F, 8'h00, 8'h02}, 1);    // runs off the end
        push_frame('{8'd1, mrs_pkg::FN_WRITE1, 8'h00, 8'h10, 8'h12, 8'h34}, 1);  // one past the end
        push_frame('{8'd1, mrs_pkg::FN_WRITEN, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03,
                     8'h11, 8'h22, 8'h33}, 1);                                   // count not 2*qty
        push_frame('{8'd1, mrs_pkg::FN_WRITEN, 8'h00, 8'h00, 8'h00, 8'h01, 8'h05,
                     8'h11, 8'h22}, 1);                                          // silently dropped
        push_frame('{8'd1, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h01}, 1);               // unknown function
        push_frame('{8'd1, mrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h01}, 0);    // bad CRC
        push_frame('{8'd7, mrs_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 8'h01}, 1);    // other slave
        push_frame('{8'd1, mrs_pkg::FN_READ, 8'h00}, 1);                         // short
        f = {};
        for (int k = 0; k < FRAME_MAX + 6; k++) f.push_back(8'($urandom));
        f[0] = 8'd1;
        push_frame(f, 1);                                                        // overflow
        push_tick();
        push_tick();

        // --- alarm at the lowest timeout, cleared by a normal answer ---
        push_cfg(mrs_pkg::CFG_TIMEOUT, 16'd0);
        push_cfg(mrs_pkg::CFG_SLAVE_ID, 16'd0);
        push_cfg(mrs_pkg::CFG_BASE, 16'd100);
        push_tick();
        push_frame('{8'd0, mrs_pkg::FN_READ, 8'h00, 8'd99, 8'h00, 8'h01}, 1);    // below base
        push_tick();
        push_frame('{8'd0, mrs_pkg::FN_READ, 8'h00, 8'd100, 8'h00, 8'h02}, 1);
        push_tick();
        push_settle();

        // --- extremes of the configuration ---
        push_cfg(mrs_pkg::CFG_SLAVE_ID, 16'd255);
        push_cfg(mrs_pkg::CFG_BASE, 16'hFFFF);
        push_cfg(mrs_pkg::CFG_TIMEOUT, 16'hFFFF);
        push_frame('{8'd255, mrs_pkg::FN_WRITE1, 8'hFF, 8'hFF, 8'hA5, 8'h5A}, 1);
        push_frame('{8'd255, mrs_pkg::FN_READ, 8'hFF, 8'hFF, 8'h00, 8'h01}, 1);
        push_frame('{8'd255, mrs_pkg::FN_WRITEN, 8'hFF, 8'hFE, 8'h00, 8'h01, 8'h02,
                     8'h12, 8'h34}, 1);
        push_tick();

        // --- random phases with fresh settings ---
        for (int ph = 0; ph < 4; ph++) begin
            push_settle();
            push_cfg(mrs_pkg::CFG_SLAVE_ID, (ph == 0) ? 16'd1 : 16'($urandom_range(0, 255)));
            push_cfg(mrs_pkg::CFG_BASE, (ph == 0) ? 16'd0 : 16'($urandom_range(0, 300)));
            push_cfg(mrs_pkg::CFG_TIMEOUT, 16'($urandom_range(0, 6)));
            while (item_total < 120 + (ph + 1) * ITEM_GOAL / 4) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) push_tick();
                end else begin
                    push_random_frame();
                end
                // stray bytes with no frame end, then a noise frame
                if ($urandom_range(0, 15) == 0) begin
                    repeat ($urandom_range(1, 3)) push_beat(1'b0, 8'($urandom), 1'b0);
                end
                if ($urandom_range(0, 7) == 0) push_settle();
            end
        end
    end

    // ---------------------------------------------------------------
    // Reset, end of test and watchdog
    // ---------------------------------------------------------------
    initial begin : finish_line
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_ops.size() > 0 || item_start || cfg_valid || awaited_beats.size() > 0)
            @(posedge i_clk);
        // drain: let a dropped frame finish its CRC walk
        repeat (1500) @(posedge i_clk);
        if (fails == 0 && awaited_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(12 * 2000000);
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mrs_pkg.sv
hw/rtl/mrs_crc.sv
hw/rtl/modbus_rtu_register_slave.sv
tb/sv/tb_modbus_rtu_register_slave.sv
